### rtl/sdbph_pkg.sv
// shared types, constants and helpers for the spectrum dB peak hold block
package sdbph_pkg;

   // level store geometry
   localparam int BIN_COUNT = 1024;
   localparam int ADDR_W    = $clog2(BIN_COUNT);
   localparam int BIN_W     = 10;
   localparam int IDX_W     = (ADDR_W + 1 > BIN_W) ? ADDR_W + 1 : BIN_W;

   // datapath widths
   localparam int CPLX_W     = 24;
   localparam int SQ_W       = 47;
   localparam int SUM_W      = 48;
   localparam int X_W        = 24;
   localparam int X_FRAC     = 23;
   localparam int LOG_FRAC   = 16;
   localparam int ZC_W       = 6;
   localparam int NRM_STEPS  = 6;
   localparam int NRM_STAGES = 3;
   localparam int NRM_PER    = 2;
   localparam int EXP_W      = 8;
   localparam int L2_W       = EXP_W + LOG_FRAC;
   localparam int LOG_K_W    = 19;
   localparam int PROD_W     = L2_W + LOG_K_W;
   localparam int PROD_SH    = 24;
   localparam int DB_W       = PROD_W - PROD_SH;
   localparam int NEW_W      = 15;
   localparam int LVL_W      = 16;

   // 10*log10(2)*256 in Q8, and the rounding half step
   localparam logic signed [LOG_K_W-1:0] LOG_K      = LOG_K_W'(197283);
   localparam logic signed [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) <<< (PROD_SH - 1);

   // configuration registers
   localparam int STEP_W     = 12;
   localparam int OFFSET_W   = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_OFFSET = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FLOOR  = CSR_IDX_W'(2);

   localparam logic [STEP_W-1:0]        DECAY_STEP_RST   = STEP_W'(512);
   localparam logic [OFFSET_W-1:0]      LEVEL_OFFSET_RST = OFFSET_W'(20480);
   localparam logic signed [LVL_W-1:0]  DECAY_FLOOR_RST  = -LVL_W'(25600);

   // control that travels with a request between the units
   typedef struct packed {
      logic             valid;
      logic [BIN_W-1:0] bin;
   } pipe_ctl_type;

   // widen a bin number so it can be compared with the store depth
   function automatic logic [IDX_W-1:0] bin_wide(input logic [BIN_W-1:0] bin);
      bin_wide = IDX_W'(bin);
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [BIN_W-1:0] bin);
      logic [IDX_W-1:0] w;
      w       = bin_wide(bin);
      addr_of = w[ADDR_W-1:0];
   endfunction

   function automatic logic in_store(input logic [BIN_W-1:0] bin);
      in_store = bin_wide(bin) < IDX_W'(BIN_COUNT);
   endfunction

endpackage

### rtl/sdbph_ram.sv
// generic single write port, single read port ram with registered read
module sdbph_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sdbph_level.sv
// pipelined level unit: squared magnitude, normalize, log2 by squaring, scale to dB
module sdbph_level
   import sdbph_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  pipe_ctl_type               in_ctl,
   input  logic signed [CPLX_W-1:0]   in_re,
   input  logic signed [CPLX_W-1:0]   in_im,
   input  logic [OFFSET_W-1:0]        level_offset,
   output pipe_ctl_type               mul_ctl,
   output pipe_ctl_type               lvl_ctl,
   output logic [NEW_W-1:0]           lvl
);

   typedef struct packed {
      logic             zero;
      logic [BIN_W-1:0] bin;
      logic [ZC_W-1:0]  zcnt;
   } stg_type;

   // valid bits per stage
   logic                  a_vld_ff, b_vld_ff, m_vld_ff, v_vld_ff;
   logic [NRM_STAGES-1:0] n_vld_ff;
   logic [LOG_FRAC-1:0]   g_vld_ff;

   // stage payloads
   logic [BIN_W-1:0]  a_bin_ff;
   logic [SQ_W-1:0]   sq_re_ff, sq_im_ff;
   stg_type           b_stg_ff;
   logic [SUM_W-1:0]  sum_ff;
   stg_type           n_stg_ff [NRM_STAGES];
   logic [SUM_W-1:0]  nrm_ff   [NRM_STAGES];
   stg_type           g_stg_ff [LOG_FRAC];
   logic [X_W-1:0]    x_ff     [LOG_FRAC];
   logic [LOG_FRAC-1:0] frac_ff [LOG_FRAC];
   stg_type           m_stg_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [BIN_W-1:0]  v_bin_ff;
   logic [NEW_W-1:0]  lvl_ff;

   // combinational next values
   logic signed [2*CPLX_W-1:0] sq_re_full, sq_im_full;
   logic [SUM_W-1:0]           sum_in;
   logic [SUM_W-1:0]           nrm_in   [NRM_STAGES];
   logic [ZC_W-1:0]            zc_in    [NRM_STAGES];
   logic [X_W-1:0]             x_in     [LOG_FRAC];
   logic [LOG_FRAC-1:0]        frac_in  [LOG_FRAC];
   logic signed [L2_W-1:0]     l2;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [DB_W+1:0]     lvl_sum;
   logic [NEW_W-1:0]           lvl_in;

   // squares of both parts
   assign sq_re_full = in_re * in_re;
   assign sq_im_full = in_im * in_im;
   assign sum_in     = SUM_W'(sq_re_ff) + SUM_W'(sq_im_ff);

   // leading-one normalize, two shift steps per stage
   always_comb begin
      logic [SUM_W-1:0] v;
      logic [ZC_W-1:0]  c;
      int               sh;
      for (int k = 0; k < NRM_STAGES; k++) begin
         v = (k == 0) ? sum_ff : nrm_ff[k-1];
         c = (k == 0) ? '0 : n_stg_ff[k-1].zcnt;
         for (int j = 0; j < NRM_PER; j++) begin
            sh = 1 << (NRM_STEPS - 1 - (k * NRM_PER + j));
            if ((v >> (SUM_W - sh)) == '0) begin
               v = v << sh;
               c = c + ZC_W'(sh);
            end
         end
         nrm_in[k] = v;
         zc_in[k]  = c;
      end
   end

   // one fraction bit of log2 per stage by squaring the mantissa
   always_comb begin
      logic [X_W-1:0]      xp;
      logic [LOG_FRAC-1:0] fp;
      logic [2*X_W-1:0]    xx;
      logic [X_W:0]        t;
      for (int j = 0; j < LOG_FRAC; j++) begin
         xp = (j == 0) ? nrm_ff[NRM_STAGES-1][SUM_W-1 -: X_W] : x_ff[j-1];
         fp = (j == 0) ? '0 : frac_ff[j-1];
         xx = xp * xp;
         t  = xx[X_FRAC +: X_W + 1];
         if (t[X_W]) begin
            x_in[j]    = t[X_W:1];
            frac_in[j] = {fp[LOG_FRAC-2:0], 1'b1};
         end else begin
            x_in[j]    = t[X_W-1:0];
            frac_in[j] = {fp[LOG_FRAC-2:0], 1'b0};
         end
      end
   end

   // log2 in Q16 is (1 - shift) in the integer part; scale to 1/256 dB
   assign l2      = {EXP_W'(1) - EXP_W'(g_stg_ff[LOG_FRAC-1].zcnt), frac_ff[LOG_FRAC-1]};
   assign prod_in = PROD_W'(l2) * PROD_W'(LOG_K) + ROUND_HALF;

   // floor shift, add offset, clamp
   always_comb begin
      lvl_sum = (DB_W+2)'(prod_ff >>> PROD_SH) + (DB_W+2)'(level_offset);
      if (m_stg_ff.zero || lvl_sum < 0) begin
         lvl_in = '0;
      end else if (lvl_sum > (DB_W+2)'({NEW_W{1'b1}})) begin
         lvl_in = '1;
      end else begin
         lvl_in = lvl_sum[NEW_W-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         n_vld_ff <= '0;
         g_vld_ff <= '0;
         m_vld_ff <= 1'b0;
         v_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_ctl.valid;
         b_vld_ff <= a_vld_ff;
         n_vld_ff <= {n_vld_ff[NRM_STAGES-2:0], b_vld_ff};
         g_vld_ff <= {g_vld_ff[LOG_FRAC-2:0], n_vld_ff[NRM_STAGES-1]};
         m_vld_ff <= g_vld_ff[LOG_FRAC-1];
         v_vld_ff <= m_vld_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         a_bin_ff <= in_ctl.bin;
         sq_re_ff <= sq_re_full[SQ_W-1:0];
         sq_im_ff <= sq_im_full[SQ_W-1:0];

         b_stg_ff.bin  <= a_bin_ff;
         b_stg_ff.zero <= (sum_in == '0);
         b_stg_ff.zcnt <= '0;
         sum_ff        <= sum_in;

         for (int k = 0; k < NRM_STAGES; k++) begin
            n_stg_ff[k].bin  <= (k == 0) ? b_stg_ff.bin : n_stg_ff[k-1].bin;
            n_stg_ff[k].zero <= (k == 0) ? b_stg_ff.zero : n_stg_ff[k-1].zero;
            n_stg_ff[k].zcnt <= zc_in[k];
            nrm_ff[k]        <= nrm_in[k];
         end

         for (int j = 0; j < LOG_FRAC; j++) begin
            g_stg_ff[j] <= (j == 0) ? n_stg_ff[NRM_STAGES-1] : g_stg_ff[j-1];
            x_ff[j]     <= x_in[j];
            frac_ff[j]  <= frac_in[j];
         end

         m_stg_ff <= g_stg_ff[LOG_FRAC-1];
         prod_ff  <= prod_in;

         v_bin_ff <= m_stg_ff.bin;
         lvl_ff   <= lvl_in;
      end
   end

   assign mul_ctl.valid = m_vld_ff;
   assign mul_ctl.bin   = m_stg_ff.bin;
   assign lvl_ctl.valid = v_vld_ff;
   assign lvl_ctl.bin   = v_bin_ff;
   assign lvl           = lvl_ff;

endmodule

### rtl/spectrum_db_peak_hold.sv
// spectrum dB peak hold top level: handshakes, registers, level store update
//
// Each request carries one frequency bin (bin number, real and imaginary
// part in signed Q1.23). The block turns its squared magnitude into a level
// of 10*log10(mag^2) plus level_offset in 1/256 dB, clamped to 0..32767,
// decays the stored level of that bin while it lies above decay_floor and
// returns the larger of the two, which is also written back to the level store.
// Throughput: one request per cycle unless rsp_ready stalls the pipeline or
// a clearing pass runs. A request passes the 16 squaring stages of the log2
// unit plus the multiply, normalize and store read-modify-write stages.
// The level store is one ram; back-to-back requests to the same bin are
// served by forwarding the last written value.
// Reset: registers return to their defaults and the store is cleared to
// zero by a pass over all BIN_COUNT addresses (1024) during which req_ready
// is low; csr writes are taken at any time outside reset.
// Stall: when rsp_ready is low with a response waiting, the whole pipeline
// holds and req_ready drops in the same cycle.
module spectrum_db_peak_hold
   import sdbph_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [BIN_W-1:0]             req_bin_index,
   input  logic signed [CPLX_W-1:0]     req_re_part,
   input  logic signed [CPLX_W-1:0]     req_im_part,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [BIN_W-1:0]             rsp_bin_out,
   output logic signed [LVL_W-1:0]      rsp_held_level
);

   // configuration registers
   logic [STEP_W-1:0]       decay_step_ff;
   logic [OFFSET_W-1:0]     level_offset_ff;
   logic signed [LVL_W-1:0] decay_floor_ff;

   // clearing pass
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // forwarding of the last store write
   logic              last_wr_vld_ff;
   logic [ADDR_W-1:0] last_wr_addr_ff;
   logic [LVL_W-1:0]  last_wr_data_ff;

   // response register
   logic                    rsp_valid_ff;
   logic [BIN_W-1:0]        rsp_bin_ff;
   logic signed [LVL_W-1:0] rsp_level_ff;

   logic                    en;
   pipe_ctl_type            in_ctl, mul_ctl, lvl_ctl;
   logic [NEW_W-1:0]        new_lvl;
   logic [LVL_W-1:0]        rd_data;
   logic [ADDR_W-1:0]       v_addr;
   logic                    v_in_store;
   logic signed [LVL_W-1:0] stored;
   logic signed [LVL_W:0]   dec_full;
   logic signed [LVL_W-1:0] decayed;
   logic signed [LVL_W-1:0] held;
   logic                    st_wr_en;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [LVL_W-1:0]        wr_data;

   // pipeline advances whenever the response register can take a value
   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en & ~clr_busy_ff;
   assign csr_ready = ~reset;

   assign in_ctl.valid = req_valid & req_ready;
   assign in_ctl.bin   = req_bin_index;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_step_ff   <= DECAY_STEP_RST;
         level_offset_ff <= LEVEL_OFFSET_RST;
         decay_floor_ff  <= DECAY_FLOOR_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DECAY_STEP:   decay_step_ff   <= csr_data[STEP_W-1:0];
            CSR_LEVEL_OFFSET: level_offset_ff <= csr_data[OFFSET_W-1:0];
            CSR_DECAY_FLOOR:  decay_floor_ff  <= $signed(csr_data[LVL_W-1:0]);
            default: ;
         endcase
      end
   end

   // level computation pipeline
   sdbph_level u_level (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_ctl       (in_ctl),
      .in_re        (req_re_part),
      .in_im        (req_im_part),
      .level_offset (level_offset_ff),
      .mul_ctl      (mul_ctl),
      .lvl_ctl      (lvl_ctl),
      .lvl          (new_lvl)
   );

   // level store
   sdbph_ram #(
      .WIDTH (LVL_W),
      .DEPTH (BIN_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (en),
      .rd_addr (addr_of(mul_ctl.bin)),
      .rd_data (rd_data)
   );

   // stored level with forwarding, decay, peak select
   assign v_addr     = addr_of(lvl_ctl.bin);
   assign v_in_store = in_store(lvl_ctl.bin);

   always_comb begin
      if (last_wr_vld_ff && last_wr_addr_ff == v_addr) begin
         stored = $signed(last_wr_data_ff);
      end else begin
         stored = $signed(rd_data);
      end
      dec_full = (LVL_W+1)'(stored) - $signed((LVL_W+1)'(decay_step_ff));
      if (stored <= decay_floor_ff) begin
         decayed = stored;
      end else if (dec_full < $signed({2'b11, {(LVL_W-1){1'b0}}})) begin
         decayed = {1'b1, {(LVL_W-1){1'b0}}};
      end else begin
         decayed = dec_full[LVL_W-1:0];
      end
      if (!v_in_store || $signed(LVL_W'(new_lvl)) > decayed) begin
         held = $signed(LVL_W'(new_lvl));
      end else begin
         held = decayed;
      end
   end

   // store write: clearing pass or update
   assign st_wr_en = en & lvl_ctl.valid & v_in_store;
   assign wr_en    = clr_busy_ff | st_wr_en;
   assign wr_addr  = clr_busy_ff ? clr_addr_ff : v_addr;
   assign wr_data  = clr_busy_ff ? '0 : held;

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(BIN_COUNT - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // last write, for a read that met it in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         last_wr_vld_ff <= 1'b0;
      end else if (en) begin
         last_wr_vld_ff <= st_wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_wr_addr_ff <= v_addr;
         last_wr_data_ff <= held;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= lvl_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_bin_ff   <= lvl_ctl.bin;
         rsp_level_ff <= held;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_out    = rsp_bin_ff;
   assign rsp_held_level = rsp_level_ff;

endmodule

### verif/spectrum_db_peak_hold_tb.sv
// testbench for the spectrum dB peak hold block: directed table, random phases, level predictor
module spectrum_db_peak_hold_tb
   import sdbph_pkg::*;
();

   localparam int CASE_COUNT  = 20;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 180;
   localparam int DRAIN_WAIT  = 30;
   localparam int PRINT_LIMIT = 50;

   localparam logic signed [CPLX_W-1:0] MAX_PART = 24'sh7FFFFF;
   localparam logic signed [CPLX_W-1:0] MIN_PART = 24'sh800000;

   // one directed request, with a typed-in level where it is obvious
   typedef struct packed {
      logic [BIN_W-1:0]         bin;
      logic signed [CPLX_W-1:0] re;
      logic signed [CPLX_W-1:0] im;
      logic                     typed;
      logic signed [LVL_W-1:0]  level;
   } bin_case_type;

   typedef struct packed {
      logic [BIN_W-1:0]        bin;
      logic signed [LVL_W-1:0] level;
   } held_result_type;

   logic                     clock;
   logic                     reset         = 1'b1;
   logic                     csr_valid     = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index     = '0;
   logic [CSR_DATA_W-1:0]    csr_data      = '0;
   logic                     req_valid     = 1'b0;
   logic                     req_ready;
   logic [BIN_W-1:0]         req_bin_index = '0;
   logic signed [CPLX_W-1:0] req_re_part   = '0;
   logic signed [CPLX_W-1:0] req_im_part   = '0;
   logic                     rsp_valid;
   logic                     rsp_ready     = 1'b0;
   logic [BIN_W-1:0]         rsp_bin_out;
   logic signed [LVL_W-1:0]  rsp_held_level;

   // predictor state: register copies and the held level of every bin
   int                      cfg_step;
   int                      cfg_offset;
   int                      cfg_floor;
   logic signed [LVL_W-1:0] level_table [BIN_COUNT];

   held_result_type expected_held_q [$];
   held_result_type due;
   int              error_count  = 0;
   int              tx_idle_pct  = 0;
   int              rx_stall_pct = 0;

   bin_case_type bin_cases [CASE_COUNT] = '{
      // zero magnitude gives level zero, no offset
      '{10'd1,    24'sd0,       24'sd0,       1'b1, 16'sd0},
      '{10'd1,    24'sd0,       24'sd0,       1'b1, 16'sd0},
      // largest magnitude on the top bin, then its peak decays back to back
      '{10'd1023, MIN_PART,     MIN_PART,     1'b1, 16'sd21251},
      '{10'd1023, 24'sd0,       24'sd0,       1'b1, 16'sd20739},
      '{10'd1023, 24'sd0,       24'sd0,       1'b1, 16'sd20227},
      // bin zero is an ordinary bin; unit magnitude gives the offset alone
      '{10'd0,    MIN_PART,     24'sd0,       1'b1, 16'sd20480},
      '{10'd0,    24'sd0,       MAX_PART,     1'b0, 16'sd0},
      // smallest magnitudes clamp to zero, then large parts of mixed sign on bins 2, 4 and 0x2AA
      '{10'd3,    24'sd1,       24'sd0,       1'b1, 16'sd0},
      '{10'd3,    24'sd0,       -24'sd1,      1'b1, 16'sd0},
      '{10'd3,    -24'sd1,      -24'sd1,      1'b1, 16'sd0},
      '{10'd2,    MAX_PART,     MAX_PART,     1'b0, 16'sd0},
      '{10'd2,    MIN_PART,     MAX_PART,     1'b0, 16'sd0},
      '{10'd4,    24'sh555555,  24'shAAAAAA,  1'b0, 16'sd0},
      '{10'h2AA,  24'shAAAAAA,  24'sh555555,  1'b0, 16'sd0},
      // normalize by right shift, then by left shift; then zero magnitude decays bin 2, and two more bins follow
      '{10'h155,  24'sd4096,    24'sd0,       1'b0, 16'sd0},
      '{10'h155,  24'sd2047,    -24'sd2047,   1'b0, 16'sd0},
      '{10'd2,    24'sd0,       24'sd0,       1'b0, 16'sd0},
      '{10'd2,    24'sd0,       24'sd0,       1'b0, 16'sd0},
      '{10'd512,  24'sh000100,  24'sh0000FF,  1'b0, 16'sd0},
      '{10'd1023, MAX_PART,     24'sd0,       1'b0, 16'sd0}
   };

   spectrum_db_peak_hold dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_bin_index  (req_bin_index),
      .req_re_part    (req_re_part),
      .req_im_part    (req_im_part),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_out    (rsp_bin_out),
      .rsp_held_level (rsp_held_level)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // level of 10*log10(mag^2) plus offset, from the squared magnitude
   function automatic int level_in_db(input logic [SUM_W-1:0] s);
      int          e;
      int          i;
      int          frac;
      logic [63:0] x;
      longint      l2;
      longint      prod;
      longint      db;
      longint      lvl;
      if (s == '0)
         return 0;
      e = 0;
      for (i = 0; i < SUM_W; i++)
         if (s[i])
            e = i;
      // mantissa in [1, 2) as Q1.23
      x = (e >= X_FRAC) ? (64'(s) >> (e - X_FRAC)) : (64'(s) << (X_FRAC - e));
      // log2 fraction bits by repeated squaring
      frac = 0;
      for (i = 0; i < LOG_FRAC; i++) begin
         x    = (x * x) >> X_FRAC;
         frac = frac << 1;
         if (x >= (64'd1 << X_W)) begin
            frac = frac | 1;
            x    = x >> 1;
         end
      end
      l2   = longint'(e - 46) * (longint'(1) << LOG_FRAC) + longint'(frac);
      prod = l2 * longint'(LOG_K) + (longint'(1) << (PROD_SH - 1));
      db   = prod >>> PROD_SH;
      lvl  = db + longint'(cfg_offset);
      if (lvl < 0)
         lvl = 0;
      if (lvl > 32767)
         lvl = 32767;
      return int'(lvl);
   endfunction

   // decay the stored level, keep the peak, write it back
   // every 10-bit bin number lies inside the store
   function automatic logic signed [LVL_W-1:0] update_bin(input logic [BIN_W-1:0] bin,
                                                          input logic signed [CPLX_W-1:0] re,
                                                          input logic signed [CPLX_W-1:0] im);
      longint re_w;
      longint im_w;
      int     new_lvl;
      int     st;
      re_w    = re;
      im_w    = im;
      new_lvl = level_in_db(SUM_W'(re_w * re_w + im_w * im_w));
      st      = level_table[bin];
      if (st > cfg_floor) begin
         st = st - cfg_step;
         if (st < -32768)
            st = -32768;
      end
      if (new_lvl > st)
         st = new_lvl;
      level_table[bin] = LVL_W'(st);
      return LVL_W'(st);
   endfunction

   // three quarters of the traffic lands on the eight lowest or eight highest bins so peak and decay history builds up
   function automatic logic [BIN_W-1:0] rand_bin();
      case ($urandom_range(3))
         0:       return BIN_W'($urandom_range(BIN_COUNT - 1));
         1, 2:    return BIN_W'($urandom_range(7));
         default: return BIN_W'(BIN_COUNT - 1 - $urandom_range(7));
      endcase
   endfunction

   // spread magnitudes over every exponent, both signs, with the extremes
   function automatic logic signed [CPLX_W-1:0] rand_component();
      logic signed [CPLX_W-1:0] v;
      v = CPLX_W'($urandom);
      case ($urandom_range(9))
         0:          return '0;
         1:          return MIN_PART;
         2:          return MAX_PART;
         3, 4, 5, 6: return v >>> $urandom_range(CPLX_W - 1);
         default:    return v;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      // keep the log short on a badly broken run
      if (error_count < PRINT_LIMIT)
         $display("mismatch: %s", msg);
      error_count++;
   endtask

   // send one request and queue its expected response on acceptance
   task automatic send_bin(input logic [BIN_W-1:0] bin,
                           input logic signed [CPLX_W-1:0] re,
                           input logic signed [CPLX_W-1:0] im,
                           input logic typed,
                           input logic signed [LVL_W-1:0] typed_level);
      held_result_type r;
      logic signed [LVL_W-1:0] held;
      if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle_pct)
            @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_bin_index <= bin;
      req_re_part   <= re;
      req_im_part   <= im;
      do
         @(posedge clock);
      while (!req_ready);
      held    = update_bin(bin, re, im);
      r.bin   = bin;
      r.level = typed ? typed_level : held;
      expected_held_q.push_back(r);
   endtask

   // stop sending and wait for every pending response
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_held_q.size() != 0)
         @(posedge clock);
   endtask

   // write all three registers back to back, predictor follows on acceptance
   task automatic write_settings(input int step, input int offset, input int floor_lvl);
      int                    k;
      int                    vals [3];
      logic [CSR_IDX_W-1:0]  idx [3];
      logic [CSR_DATA_W-1:0] d;
      vals = '{step, offset, floor_lvl};
      idx  = '{CSR_DECAY_STEP, CSR_LEVEL_OFFSET, CSR_DECAY_FLOOR};
      for (k = 0; k < 3; k++) begin
         d = CSR_DATA_W'(vals[k]);
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= d;
         do
            @(posedge clock);
         while (!csr_ready);
         case (idx[k])
            CSR_DECAY_STEP:   cfg_step   = int'(d[STEP_W-1:0]);
            CSR_LEVEL_OFFSET: cfg_offset = int'(d[OFFSET_W-1:0]);
            CSR_DECAY_FLOOR:  cfg_floor  = int'($signed(d));
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // response side back-pressure
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= rx_stall_pct);

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_held_q.size() == 0) begin
            report_mismatch($sformatf("response for bin %0d with nothing pending", rsp_bin_out));
         end else begin
            due = expected_held_q.pop_front();
            if (rsp_bin_out !== due.bin)
               report_mismatch($sformatf("bin_out %0d, expected %0d", rsp_bin_out, due.bin));
            if (rsp_held_level !== due.level)
               report_mismatch($sformatf("bin %0d: held_level %0d, expected %0d",
                                         due.bin, rsp_held_level, due.level));
         end
      end
   end

   // main sequence: reset, directed table, then random phases
   initial begin
      int ph;
      int n;
      for (n = 0; n < BIN_COUNT; n++)
         level_table[n] = '0;
      cfg_step   = int'(DECAY_STEP_RST);
      cfg_offset = int'(LEVEL_OFFSET_RST);
      cfg_floor  = int'(DECAY_FLOOR_RST);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed requests at the reset settings, no idling
      for (n = 0; n < CASE_COUNT; n++)
         send_bin(bin_cases[n].bin, bin_cases[n].re, bin_cases[n].im,
                  bin_cases[n].typed, bin_cases[n].level);

      for (ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            settle();
            case (ph)
               1:       write_settings(2560, 0, -26112);
               2:       write_settings(0, 25600, 0);
               3:       write_settings(1, 25600, -26112);
               4:       write_settings(2560, 1, 0);
               default: write_settings($urandom_range(2560), $urandom_range(25600),
                                       -int'($urandom_range(26112)));
            endcase
         end
         // idling pattern rotates: none, sender, receiver, both
         case (ph % 4)
            0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1:       begin tx_idle_pct = 61; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 61; end
            default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++)
            send_bin(rand_bin(), rand_component(), rand_component(), 1'b0, '0);
      end

      settle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

### spectrum_db_peak_hold.f
rtl/sdbph_pkg.sv
rtl/sdbph_ram.sv
rtl/sdbph_level.sv
rtl/spectrum_db_peak_hold.sv
verif/spectrum_db_peak_hold_tb.sv
